[hdl/str_pkg.sv]
// ----------------------------------------------------------------------------
// str_pkg
// Shared types and codes for the square tile rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package str_pkg;

   localparam int unsigned CELL_W  = 13;
   localparam int unsigned COORD_W = 7;
   localparam int unsigned RAD_W   = 5;

   localparam logic [1:0] OP_INIT   = 2'd0;
   localparam logic [1:0] OP_ROTATE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [RAD_W-1:0]   radius;
      logic               direction;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0] value;
      logic              error;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/str_ram.sv]
// ----------------------------------------------------------------------------
// str_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module str_ram #(
   parameter int unsigned WIDTH = 13,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/square_tile_rotator.sv]
// ----------------------------------------------------------------------------
// square_tile_rotator
// Grid of cells with initialize, 90-degree square rotate and cell read.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one transaction per operation (initialize, rotate, read), taken
//           when req_valid is high and req_stall low. req_stall is high while
//           an operation is in progress; the block works on one at a time.
//   rsp_* : exactly one transaction per request, in order, with value (read
//           only) and error. The result sits in an output register, so a
//           new request is taken while an old result waits on rsp_stall.
//           A finished operation holds in its last step until that register
//           frees up.
//   csr_* : writes grid_size; always ready. Write only while idle.
// Steps per operation, from accept to result valid:
//   initialize : one grid write per cycle over the whole grid
//   rotate     : copy pass into scratch, then turned write-back, one cell
//                per cycle each
//   read       : registered RAM read
//   any error  : no memory access, nothing changes
// Reset: grid_size goes to 64, sequencer to idle, no result pending. Grid
// and scratch contents are undefined until written; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module square_tile_rotator
   import str_pkg::*;
#(
   parameter int unsigned MAX_SIDE = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire req_type             req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_type                  rsp_data,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [COORD_W-1:0]  csr_data
);

   localparam int unsigned DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // sequencer codes
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_INIT   = 3'd1;
   localparam logic [2:0] S_COPY   = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_TURN   = 3'd4;
   localparam logic [2:0] S_READ   = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   // linear cell address from 0-based row and column
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                   input logic [COORD_W-1:0] c);
      logic [31:0] lin;
      lin = 32'(r) * 32'(MAX_SIDE) + 32'(c);
      return lin[ADDR_W-1:0];
   endfunction

   // control state
   logic [2:0]         state_ff, state_in;
   logic [COORD_W-1:0] grid_size_ff;
   logic               rsp_valid_ff;
   logic               wr_pend_ff;

   // operation payload
   logic [1:0]         op_ff;
   logic               err_ff;
   logic               dir_ff;
   logic [COORD_W-1:0] top_ff, left_ff, last_ff;
   logic [COORD_W-1:0] i_ff, j_ff;
   logic [CELL_W-1:0]  init_val_ff;
   logic               wr_grid_ff;
   logic [ADDR_W-1:0]  wr_addr_ff;
   rsp_type            rsp_data_ff;

   logic               req_take;
   logic               rsp_free;
   logic [COORD_W-1:0] side;
   logic [COORD_W:0]   row8, col8, rad8, side8;
   logic               rot_err, rd_err, acc_err;
   logic               last_cell;
   logic [COORD_W-1:0] si, sj;
   logic [ADDR_W-1:0]  cur_addr, src_addr;

   logic               grid_wr_en, grid_rd_en, scr_wr_en, scr_rd_en;
   logic [ADDR_W-1:0]  grid_wr_addr;
   logic [CELL_W-1:0]  grid_wr_data, grid_rd_data, scr_rd_data;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // side in use, limited to the memory's side
   assign side = (32'(grid_size_ff) > MAX_SIDE) ? COORD_W'(MAX_SIDE) : grid_size_ff;

   // bounds checks on the incoming request, one bit wider to avoid wrap
   assign row8    = {1'b0, req_data.row};
   assign col8    = {1'b0, req_data.col};
   assign rad8    = {3'b0, req_data.radius};
   assign side8   = {1'b0, side};
   assign rot_err = (row8 < rad8 + 8'd1) || (row8 + rad8 > side8) ||
                    (col8 < rad8 + 8'd1) || (col8 + rad8 > side8);
   assign rd_err  = (req_data.row == '0) || (row8 > side8) ||
                    (req_data.col == '0) || (col8 > side8);

   always_comb begin
      unique case (req_data.operation)
         OP_INIT:   acc_err = 1'b0;
         OP_ROTATE: acc_err = rot_err;
         OP_READ:   acc_err = rd_err;
         default:   acc_err = 1'b1;
      endcase
   end

   // scan position and source cell of the turned write-back
   assign last_cell = (i_ff == last_ff) && (j_ff == last_ff);
   assign si        = dir_ff ? j_ff : (last_ff - j_ff);
   assign sj        = dir_ff ? (last_ff - i_ff) : i_ff;
   assign cur_addr  = cell_addr(top_ff + i_ff, left_ff + j_ff);
   assign src_addr  = cell_addr(top_ff + si, left_ff + sj);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (acc_err) begin
                  state_in = S_FINISH;
               end else begin
                  unique case (req_data.operation)
                     OP_INIT:   state_in = (side == '0) ? S_FINISH : S_INIT;
                     OP_ROTATE: state_in = S_COPY;
                     default:   state_in = S_READ;
                  endcase
               end
            end
         end
         S_INIT:   if (last_cell) state_in = S_FINISH;
         S_COPY:   if (last_cell) state_in = S_DRAIN;
         S_DRAIN:  state_in = S_TURN;
         S_TURN:   if (last_cell) state_in = S_FINISH;
         S_READ:   state_in = S_FINISH;
         S_FINISH: if (rsp_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         grid_size_ff <= COORD_W'(64);
         rsp_valid_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wr_pend_ff <= (state_ff == S_COPY) || (state_ff == S_TURN);
         if (csr_valid && csr_ready) begin
            grid_size_ff <= csr_data;
         end
         if (state_ff == S_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      wr_grid_ff <= (state_ff == S_TURN);
      wr_addr_ff <= cur_addr;

      if (req_take) begin
         op_ff       <= req_data.operation;
         err_ff      <= acc_err;
         dir_ff      <= req_data.direction;
         i_ff        <= '0;
         j_ff        <= '0;
         init_val_ff <= CELL_W'(1);
         unique case (req_data.operation)
            OP_ROTATE: begin
               top_ff  <= req_data.row - COORD_W'(req_data.radius) - COORD_W'(1);
               left_ff <= req_data.col - COORD_W'(req_data.radius) - COORD_W'(1);
               last_ff <= {1'b0, req_data.radius, 1'b0};
            end
            OP_READ: begin
               top_ff  <= req_data.row - COORD_W'(1);
               left_ff <= req_data.col - COORD_W'(1);
               last_ff <= '0;
            end
            default: begin
               top_ff  <= '0;
               left_ff <= '0;
               last_ff <= side - COORD_W'(1);
            end
         endcase
      end else if (state_ff == S_INIT || state_ff == S_COPY || state_ff == S_TURN) begin
         init_val_ff <= init_val_ff + CELL_W'(1);
         if (j_ff == last_ff) begin
            j_ff <= '0;
            i_ff <= last_cell ? '0 : i_ff + COORD_W'(1);
         end else begin
            j_ff <= j_ff + COORD_W'(1);
         end
      end

      if (state_ff == S_FINISH && rsp_free) begin
         rsp_data_ff.error <= err_ff;
         rsp_data_ff.value <= (op_ff == OP_READ && !err_ff) ? grid_rd_data : '0;
      end
   end

   // memory ports: copy pass reads grid and writes scratch in the next cycle;
   // the turned pass reads scratch and writes grid in the next cycle
   assign grid_wr_en   = (state_ff == S_INIT) || (wr_pend_ff && wr_grid_ff);
   assign grid_wr_addr = (state_ff == S_INIT) ? cur_addr : wr_addr_ff;
   assign grid_wr_data = (state_ff == S_INIT) ? init_val_ff : scr_rd_data;
   assign grid_rd_en   = (state_ff == S_COPY) || (state_ff == S_READ);
   assign scr_wr_en    = wr_pend_ff && !wr_grid_ff;
   assign scr_rd_en    = (state_ff == S_TURN);

   str_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (grid_wr_en),
      .wr_addr (grid_wr_addr),
      .wr_data (grid_wr_data),
      .rd_en   (grid_rd_en),
      .rd_addr (cur_addr),
      .rd_data (grid_rd_data)
   );

   str_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_scratch_ram (
      .clock   (clock),
      .wr_en   (scr_wr_en),
      .wr_addr (wr_addr_ff),
      .wr_data (grid_rd_data),
      .rd_en   (scr_rd_en),
      .rd_addr (src_addr),
      .rd_data (scr_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != S_IDLE))
      else $error("sequencer idle after taking a request");

   a_pend_source: assert property (@(posedge clock) disable iff (reset)
      (wr_pend_ff && !$past(reset)) |->
         ($past(state_ff) == S_COPY || $past(state_ff) == S_TURN))
      else $error("deferred write without a copy or turn cycle");

   a_scan_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT || state_ff == S_COPY || state_ff == S_TURN) |->
         (i_ff <= last_ff && j_ff <= last_ff))
      else $error("scan position beyond square");

   a_error_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.error) |-> (rsp_data_ff.value == '0))
      else $error("error result carries a value");

   a_no_drain_write_clash: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TURN) |-> !scr_wr_en)
      else $error("scratch written while the turned pass reads it");

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Testbench for square_tile_rotator
// Drives initialize, rotate and read transactions into the rotator, keeps a
// shadow copy of the grid to work out each expected result, and checks every
// result transaction in order. Covers grid sizes from 0 up to the 7-bit
// maximum, random gaps on both channels and a long output back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import str_pkg::*;

   localparam int          SIDE_MAX   = 64;
   localparam logic [1:0]  OP_UNKNOWN = 2'd3;
   localparam logic        DIR_CW     = 1'b0;
   localparam logic        DIR_CCW    = 1'b1;
   localparam int          RAND_ITEMS = 60;

   // ---- DUT signals; every input known from time zero ----
   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [COORD_W-1:0] csr_data  = '0;

   // ---- shadow state of the grid ----
   logic [CELL_W-1:0] grid_shadow    [0:SIDE_MAX*SIDE_MAX-1];
   logic [CELL_W-1:0] scratch_shadow [0:SIDE_MAX*SIDE_MAX-1];
   int                size_shadow = 64;

   rsp_type expected_results [$];
   int      mismatch_count   = 0;

   // idling controls of sender and receiver
   bit req_idling      = 1'b1;
   bit rsp_idling      = 1'b1;
   int rsp_hold_cycles = 0;
   int rsp_wait_left   = 0;

   square_tile_rotator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard limit: the run fails if the worst case of roughly 110 transactions
   // plus all the gaps has not finished by this time.
   initial begin
      #50_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Shadow model
   // ------------------------------------------------------------------------
   function automatic int cell_index(int r, int c);
      return (r - 1) * SIDE_MAX + (c - 1);
   endfunction

   // Applies one request to the shadow grid and returns the result it gives.
   task automatic predict_tile_op(input req_type t, output rsp_type r);
      int side, row, col, rad, top, left, last, si, sj;
      side = (size_shadow > SIDE_MAX) ? SIDE_MAX : size_shadow;
      row  = int'(t.row);
      col  = int'(t.col);
      rad  = int'(t.radius);
      r    = '0;
      case (t.operation)
         OP_INIT: begin
            for (int i = 1; i <= side; i++)
               for (int j = 1; j <= side; j++)
                  grid_shadow[cell_index(i, j)] = CELL_W'((i - 1) * side + j);
         end
         OP_ROTATE: begin
            if (row < rad + 1 || row + rad > side || col < rad + 1 || col + rad > side) begin
               r.error = 1'b1;
            end else begin
               top  = row - rad;
               left = col - rad;
               last = 2 * rad;
               // copy pass into scratch, then turned write-back
               for (int i = 0; i <= last; i++)
                  for (int j = 0; j <= last; j++)
                     scratch_shadow[cell_index(top + i, left + j)] =
                        grid_shadow[cell_index(top + i, left + j)];
               for (int i = 0; i <= last; i++)
                  for (int j = 0; j <= last; j++) begin
                     if (t.direction == DIR_CCW) begin
                        si = j;
                        sj = last - i;
                     end else begin
                        si = last - j;
                        sj = i;
                     end
                     grid_shadow[cell_index(top + i, left + j)] =
                        scratch_shadow[cell_index(top + si, left + sj)];
                  end
            end
         end
         OP_READ: begin
            if (row < 1 || row > side || col < 1 || col > side)
               r.error = 1'b1;
            else
               r.value = grid_shadow[cell_index(row, col)];
         end
         default: r.error = 1'b1;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Result side: stall timing and checking
   // ------------------------------------------------------------------------

   // Stall is changed on the falling edge only. A long hold requested by a
   // test is counted down here, cycle by cycle, ahead of the per-item wait.
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_stall <= 1'b1;
      end else if (rsp_wait_left > 0) begin
         rsp_wait_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Each accepted result transaction is compared with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_wait_left = rsp_idling ? $urandom_range(0, 14) : 0;
         if (expected_results.size() == 0) begin
            $error("result transaction with nothing expected: value %0d error %0b",
                   rsp_data.value, rsp_data.error);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.value !== want.value) begin
               $error("value: expected %0d, got %0d", want.value, rsp_data.value);
               mismatch_count++;
            end
            if (rsp_data.error !== want.error) begin
               $error("error: expected %0b, got %0b", want.error, rsp_data.error);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   function automatic req_type tile_req(logic [1:0] op, int row, int col, int rad,
                                        logic dir);
      req_type t;
      t.operation = op;
      t.row       = COORD_W'(row);
      t.col       = COORD_W'(col);
      t.radius    = RAD_W'(rad);
      t.direction = dir;
      return t;
   endfunction

   // Offers one request transaction; the prediction is queued at acceptance.
   // Valid is only lowered when a gap is drawn, so a back-to-back transaction
   // never sees valid dropped and raised in the same step.
   task automatic send_tile_op(input req_type t);
      int      gap;
      rsp_type r;
      gap = req_idling ? $urandom_range(0, 14) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
      predict_tile_op(t, r);
      expected_results.push_back(r);
   endtask

   // Withdraws the last offer so it is not taken twice, then waits for
   // every outstanding result.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Register writes happen only with nothing in flight.
   task automatic write_grid_size(int size);
      wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_data  <= COORD_W'(size);
      do @(posedge clock); while (!csr_ready);
      size_shadow = size & 'h7F;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Fills the whole 64x64 memory first, so no later read hits an unwritten
   // cell whatever grid size is in use afterwards.
   task automatic test_initialize_and_read();
      send_tile_op(tile_req(OP_INIT,     0,   0,  0, DIR_CW));
      send_tile_op(tile_req(OP_READ,     1,   1,  0, DIR_CW));
      send_tile_op(tile_req(OP_READ,     1,  64,  0, DIR_CW));
      send_tile_op(tile_req(OP_READ,    64,   1,  0, DIR_CW));
      send_tile_op(tile_req(OP_READ,    64,  64,  0, DIR_CW));
      // cells outside the grid
      send_tile_op(tile_req(OP_READ,     0,   5,  0, DIR_CW));
      send_tile_op(tile_req(OP_READ,   127, 127, 31, DIR_CCW));
      // unknown operation with every field bit set
      send_tile_op(tile_req(OP_UNKNOWN, 127, 127, 31, DIR_CCW));
   endtask

   task automatic test_rotate();
      send_tile_op(tile_req(OP_ROTATE,  2,  2,  1, DIR_CW));
      send_tile_op(tile_req(OP_READ,    1,  3,  0, DIR_CW));
      send_tile_op(tile_req(OP_ROTATE,  2,  2,  1, DIR_CCW));
      send_tile_op(tile_req(OP_ROTATE, 10, 20,  0, DIR_CW));   // single cell
      // squares poking out over each border
      send_tile_op(tile_req(OP_ROTATE,  1,  1,  1, DIR_CW));
      send_tile_op(tile_req(OP_ROTATE, 64, 64,  1, DIR_CCW));
      send_tile_op(tile_req(OP_ROTATE, 32, 34, 31, DIR_CW));
      // largest square, both ways
      send_tile_op(tile_req(OP_ROTATE, 32, 32, 31, DIR_CW));
      send_tile_op(tile_req(OP_READ,    2,  2,  0, DIR_CW));
      send_tile_op(tile_req(OP_ROTATE, 33, 33, 31, DIR_CCW));
      send_tile_op(tile_req(OP_READ,   63, 63,  0, DIR_CW));
   endtask

   // Extreme grid sizes: 1, 0 (nothing valid) and above the memory side.
   task automatic test_grid_sizes();
      write_grid_size(1);
      send_tile_op(tile_req(OP_INIT,    0, 0, 0, DIR_CW));
      send_tile_op(tile_req(OP_READ,    1, 1, 0, DIR_CW));
      send_tile_op(tile_req(OP_READ,    1, 2, 0, DIR_CW));
      send_tile_op(tile_req(OP_ROTATE,  1, 1, 0, DIR_CCW));
      write_grid_size(0);
      send_tile_op(tile_req(OP_INIT,    0, 0, 0, DIR_CW));
      send_tile_op(tile_req(OP_READ,    1, 1, 0, DIR_CW));
      write_grid_size(127);
      send_tile_op(tile_req(OP_READ,   64, 64, 0, DIR_CW));
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering
   // back-to-back reads, so the result register and the sequencer both fill
   // and req_stall has to hold the sender off.
   task automatic test_backpressure();
      write_grid_size(64);
      req_idling      = 1'b0;
      rsp_idling      = 1'b0;
      rsp_hold_cycles = 400;
      for (int k = 0; k < 8; k++)
         send_tile_op(tile_req(OP_READ, $urandom_range(1, 64), $urandom_range(1, 64), 0,
                               DIR_CW));
      wait_drained();    // sender pauses until everything is back
      req_idling = 1'b1;
      rsp_idling = 1'b1;
   endtask

   // Random phases, each with its own grid size and idling mix, each opening
   // with an initialize. Most further transactions are well-formed rotates and
   // reads inside the grid; the rest is raw noise over every field.
   task automatic test_random();
      int sent, side, n_ops, kind, rad, rad_max;
      sent = 0;
      while (sent < RAND_ITEMS) begin
         case ($urandom_range(0, 11))
            0, 1:    side = 64;
            2:       side = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 127);
            default: side = $urandom_range(1, 16);
         endcase
         write_grid_size(side);
         if (side > SIDE_MAX) side = SIDE_MAX;
         req_idling = ($urandom_range(0, 3) != 0);
         rsp_idling = ($urandom_range(0, 3) != 0);
         send_tile_op(tile_req(OP_INIT, $urandom_range(0, 127), $urandom_range(0, 127),
                               $urandom_range(0, 31), 1'($urandom_range(0, 1))));
         sent++;
         n_ops = $urandom_range(6, 14);
         for (int k = 0; k < n_ops; k++) begin
            kind = (side == 0) ? 8 : $urandom_range(0, 9);
            case (kind)
               0, 1, 2, 3: begin
                  rad_max = (side - 1) / 2;
                  // big squares are slow; keep them rare
                  if ($urandom_range(0, 9) == 0)
                     rad = $urandom_range(0, rad_max);
                  else
                     rad = $urandom_range(0, (rad_max < 3) ? rad_max : 3);
                  send_tile_op(tile_req(OP_ROTATE, $urandom_range(rad + 1, side - rad),
                                        $urandom_range(rad + 1, side - rad), rad,
                                        1'($urandom_range(0, 1))));
               end
               4, 5, 6, 7:
                  send_tile_op(tile_req(OP_READ, $urandom_range(1, side),
                                        $urandom_range(1, side), $urandom_range(0, 31),
                                        1'($urandom_range(0, 1))));
               8:
                  send_tile_op(req_type'($urandom));
               default: begin
                  wait_drained();
                  send_tile_op(tile_req(OP_READ, $urandom_range(1, side),
                                        $urandom_range(1, side), 0, DIR_CW));
               end
            endcase
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_initialize_and_read();
      test_rotate();
      test_grid_sizes();
      test_backpressure();
      test_random();

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      // wait on to catch any stray result transaction
      repeat (20) @(posedge clock);

      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
hdl/str_pkg.sv
hdl/str_ram.sv
hdl/square_tile_rotator.sv
tb/testbench.sv
